// ===== hw/rtl/hbp_pkg.sv =====
`default_nettype none
package hbp_pkg;

  localparam int BIMODAL_INDEX_MAX_DEF = 12;
  localparam int GSHARE_INDEX_MAX_DEF  = 12;
  localparam int CHOOSER_INDEX_MAX_DEF = 12;

  localparam int ADDR_W = 32;
  localparam int CTR_W  = 3;
  localparam int SEL_W  = 2;
  localparam int CFG_W  = 4;
  localparam int CFG_AW = 3;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  localparam logic [CTR_W-1:0] CTR_INIT     = 3'd4;
  localparam logic [CTR_W-1:0] CTR_TOP      = 3'd7;
  localparam logic [CTR_W-1:0] CTR_TAKEN_AT = 3'd4;
  localparam logic [SEL_W-1:0] SEL_INIT      = 2'd1;
  localparam logic [SEL_W-1:0] SEL_TOP       = 2'd3;
  localparam logic [SEL_W-1:0] SEL_GSHARE_AT = 2'd2;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] REG_MODE        = 3'd0;
  localparam logic [CFG_AW-1:0] REG_BIMODAL_BITS = 3'd1;
  localparam logic [CFG_AW-1:0] REG_GSHARE_BITS = 3'd2;
  localparam logic [CFG_AW-1:0] REG_HISTORY_BITS = 3'd3;
  localparam logic [CFG_AW-1:0] REG_CHOOSER_BITS = 3'd4;

  localparam logic [1:0] MODE_BIMODAL = 2'd0;
  localparam logic [1:0] MODE_GSHARE  = 2'd1;

  typedef struct packed {
    logic [1:0]       mode;
    logic [CFG_W-1:0] bimodal_bits;
    logic [CFG_W-1:0] gshare_bits;
    logic [CFG_W-1:0] history_bits;
    logic [CFG_W-1:0] chooser_bits;
  } hbp_cfg_t;

  function automatic logic [CFG_W-1:0] clamp_bits(input logic [CFG_W-1:0] v,
                                                  input logic [4:0] maxv);
    logic [CFG_W-1:0] res;
    res = ({1'b0, v} > maxv) ? maxv[CFG_W-1:0] : v;
    return res;
  endfunction

  function automatic logic [CTR_W-1:0] ctr_train(input logic [CTR_W-1:0] c,
                                                 input logic t);
    logic [CTR_W-1:0] res;
    if (t) begin
      res = (c < CTR_TOP) ? c + 3'd1 : CTR_TOP;
    end else begin
      res = (c != '0) ? c - 3'd1 : '0;
    end
    return res;
  endfunction

  function automatic logic [SEL_W-1:0] sel_train(input logic [SEL_W-1:0] s,
                                                 input logic g_ok, input logic b_ok);
    logic [SEL_W-1:0] res;
    res = s;
    if (g_ok && !b_ok) begin
      res = (s < SEL_TOP) ? s + 2'd1 : SEL_TOP;
    end else if (b_ok && !g_ok) begin
      res = (s != '0) ? s - 2'd1 : '0;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/hbp_ctr_ram.sv =====
`default_nettype none
module hbp_ctr_ram #(
  parameter int AW = 12,
  parameter int DW = 3
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== hw/rtl/hbp_index.sv =====
`default_nettype none
module hbp_index #(
  parameter int BI_MAX = 12,
  parameter int GI_MAX = 12,
  parameter int CI_MAX = 12
) (
  input  logic [31:0]        pc,
  input  logic               taken,
  input  hbp_pkg::hbp_cfg_t  cfg,
  input  logic [GI_MAX-1:0]  hist,
  output logic [BI_MAX-1:0]  bi,
  output logic [GI_MAX-1:0]  gi,
  output logic [CI_MAX-1:0]  ci,
  output logic [GI_MAX-1:0]  hist_new
);
  import hbp_pkg::*;

  logic [CFG_W-1:0]  mb;
  logic [CFG_W-1:0]  mg;
  logic [CFG_W-1:0]  mc;
  logic [CFG_W-1:0]  nh;
  logic [GI_MAX-1:0] hm;
  logic [GI_MAX-1:0] hs;

  assign mb = clamp_bits(cfg.bimodal_bits, 5'(BI_MAX));
  assign mg = clamp_bits(cfg.gshare_bits, 5'(GI_MAX));
  assign mc = clamp_bits(cfg.chooser_bits, 5'(CI_MAX));
  // history length never exceeds the effective gshare index width
  assign nh = clamp_bits(cfg.history_bits, {1'b0, mg});
  assign hs = hm >> 1;

  always_comb begin
    for (int i = 0; i < BI_MAX; i++) begin
      bi[i] = pc[i+2] & (5'(i) < {1'b0, mb});
    end
    for (int i = 0; i < CI_MAX; i++) begin
      ci[i] = pc[i+2] & (5'(i) < {1'b0, mc});
    end
    for (int i = 0; i < GI_MAX; i++) begin
      hm[i] = hist[i] & (5'(i) < {1'b0, nh});
    end
    for (int i = 0; i < GI_MAX; i++) begin
      gi[i] = (pc[i+2] & (5'(i) < {1'b0, mg})) ^ hm[i];
      // newest outcome lands at bit nh-1, older bits move down
      if (5'(i + 1) < {1'b0, nh}) begin
        hist_new[i] = hs[i];
      end else if (5'(i + 1) == {1'b0, nh}) begin
        hist_new[i] = taken;
      end else begin
        hist_new[i] = 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/hybrid_branch_predictor_top.sv =====
`default_nettype none
// Tournament branch predictor (bimodal + gshare with a 2-bit chooser) with 3-bit
// counters. Each transfer on in_ carries a resolved branch; one result per branch
// leaves on out_ with the prediction, the miss flag, the table used and the
// saturating miss total. The accept cycle reads the bimodal, gshare and chooser
// memories; once the output register is free, the resolve state writes back the used
// counter (and chooser if mode[1]); the round trip keeps new branches out until then.
// A finished result may wait in the output register while the next branch is
// taken in. After reset a clearing pass initializes every table entry; in_tready
// stays low until it ends. Configuration writes go through cfg_wr_en/cfg_addr/cfg_wdata
// at any time and must only be issued while no branch is in flight.
module hybrid_branch_predictor_top #(
  parameter int BIMODAL_INDEX_MAX = hbp_pkg::BIMODAL_INDEX_MAX_DEF,
  parameter int GSHARE_INDEX_MAX  = hbp_pkg::GSHARE_INDEX_MAX_DEF,
  parameter int CHOOSER_INDEX_MAX = hbp_pkg::CHOOSER_INDEX_MAX_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [31:0] branch_address, [32] taken
  input  logic [hbp_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] predicted_taken, [1] mispredicted, [2] used_gshare, [34:3] miss_total
  output logic [hbp_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                             cfg_wr_en,
  input  logic [hbp_pkg::CFG_AW-1:0]       cfg_addr,
  input  logic [hbp_pkg::CFG_W-1:0]        cfg_wdata
);
  import hbp_pkg::*;

  localparam int BG_MAX = (BIMODAL_INDEX_MAX > GSHARE_INDEX_MAX) ?
                          BIMODAL_INDEX_MAX : GSHARE_INDEX_MAX;
  localparam int IW_MAX = (BG_MAX > CHOOSER_INDEX_MAX) ? BG_MAX : CHOOSER_INDEX_MAX;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_LOOK  = 3'b100
  } state_t;

  state_t                     state_r, state_nxt;
  logic [IW_MAX-1:0]          clr_cnt_r;
  hbp_cfg_t                   cfg_r;
  logic [GSHARE_INDEX_MAX-1:0]  hist_r;
  logic [BIMODAL_INDEX_MAX-1:0] bi_r;
  logic [GSHARE_INDEX_MAX-1:0]  gi_r;
  logic [CHOOSER_INDEX_MAX-1:0] ci_r;
  logic                       taken_r;
  logic [ADDR_W-1:0]          miss_cnt_r, miss_cnt_nxt;
  logic                       out_valid_r;
  logic                       out_pred_r, out_miss_r, out_useg_r;
  logic [ADDR_W-1:0]          out_total_r;

  logic                       accept, clearing, look_go;
  logic [BIMODAL_INDEX_MAX-1:0] bi;
  logic [GSHARE_INDEX_MAX-1:0]  gi;
  logic [CHOOSER_INDEX_MAX-1:0] ci;
  logic [GSHARE_INDEX_MAX-1:0]  hist_new;
  logic [CTR_W-1:0]           b_rdata, g_rdata;
  logic [SEL_W-1:0]           c_rdata;
  logic                       bpred, gpred, use_g, pred, miss;
  logic                       b_we, g_we, c_we;
  logic [BIMODAL_INDEX_MAX-1:0] b_waddr;
  logic [GSHARE_INDEX_MAX-1:0]  g_waddr;
  logic [CHOOSER_INDEX_MAX-1:0] c_waddr;
  logic [CTR_W-1:0]           b_wdata, g_wdata;
  logic [SEL_W-1:0]           c_wdata;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign clearing  = (state_r == S_CLEAR);
  assign look_go   = (state_r == S_LOOK) && (!out_valid_r || out_tready);

  hbp_index #(
    .BI_MAX(BIMODAL_INDEX_MAX),
    .GI_MAX(GSHARE_INDEX_MAX),
    .CI_MAX(CHOOSER_INDEX_MAX)
  ) u_index (
    .pc       (in_tdata[ADDR_W-1:0]),
    .taken    (in_tdata[ADDR_W]),
    .cfg      (cfg_r),
    .hist     (hist_r),
    .bi       (bi),
    .gi       (gi),
    .ci       (ci),
    .hist_new (hist_new)
  );

  // resolve stage
  assign bpred = (b_rdata >= CTR_TAKEN_AT);
  assign gpred = (g_rdata >= CTR_TAKEN_AT);
  always_comb begin
    case (cfg_r.mode)
      MODE_BIMODAL: use_g = 1'b0;
      MODE_GSHARE:  use_g = 1'b1;
      default:      use_g = (c_rdata >= SEL_GSHARE_AT);
    endcase
  end
  assign pred = use_g ? gpred : bpred;
  assign miss = (pred != taken_r);
  assign miss_cnt_nxt = (miss && (miss_cnt_r != '1)) ? miss_cnt_r + 32'd1 : miss_cnt_r;

  // clearing pass shares the write ports with the update
  assign b_we    = clearing ? ((clr_cnt_r >> BIMODAL_INDEX_MAX) == '0) : (look_go && !use_g);
  assign b_waddr = clearing ? clr_cnt_r[BIMODAL_INDEX_MAX-1:0] : bi_r;
  assign b_wdata = clearing ? CTR_INIT : ctr_train(b_rdata, taken_r);
  assign g_we    = clearing ? ((clr_cnt_r >> GSHARE_INDEX_MAX) == '0) : (look_go && use_g);
  assign g_waddr = clearing ? clr_cnt_r[GSHARE_INDEX_MAX-1:0] : gi_r;
  assign g_wdata = clearing ? CTR_INIT : ctr_train(g_rdata, taken_r);
  assign c_we    = clearing ? ((clr_cnt_r >> CHOOSER_INDEX_MAX) == '0) :
                              (look_go && cfg_r.mode[1]);
  assign c_waddr = clearing ? clr_cnt_r[CHOOSER_INDEX_MAX-1:0] : ci_r;
  assign c_wdata = clearing ? SEL_INIT :
                   sel_train(c_rdata, gpred == taken_r, bpred == taken_r);

  hbp_ctr_ram #(.AW(BIMODAL_INDEX_MAX), .DW(CTR_W)) u_bimodal_ram (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .re(accept), .raddr(bi), .rdata(b_rdata)
  );

  hbp_ctr_ram #(.AW(GSHARE_INDEX_MAX), .DW(CTR_W)) u_gshare_ram (
    .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
    .re(accept), .raddr(gi), .rdata(g_rdata)
  );

  hbp_ctr_ram #(.AW(CHOOSER_INDEX_MAX), .DW(SEL_W)) u_chooser_ram (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .re(accept), .raddr(ci), .rdata(c_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_cnt_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        if (look_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_cnt_r    <= '0;
      hist_r       <= '0;
      miss_cnt_r   <= '0;
      out_valid_r  <= 1'b0;
      cfg_r.mode         <= MODE_BIMODAL;
      cfg_r.bimodal_bits <= 4'd12;
      cfg_r.gshare_bits  <= 4'd12;
      cfg_r.history_bits <= 4'd8;
      cfg_r.chooser_bits <= 4'd12;
    end else begin
      state_r <= state_nxt;
      if (clearing) begin
        clr_cnt_r <= clr_cnt_r + IW_MAX'(1);
      end
      if (cfg_wr_en) begin
        case (cfg_addr)
          REG_MODE:         cfg_r.mode         <= cfg_wdata[1:0];
          REG_BIMODAL_BITS: cfg_r.bimodal_bits <= cfg_wdata;
          REG_GSHARE_BITS:  cfg_r.gshare_bits  <= cfg_wdata;
          REG_HISTORY_BITS: cfg_r.history_bits <= cfg_wdata;
          REG_CHOOSER_BITS: cfg_r.chooser_bits <= cfg_wdata;
          default: ;
        endcase
      end
      // history needs no table read, just the outcome, so it moves at accept
      if (accept) begin
        hist_r <= hist_new;
      end
      if (look_go) begin
        miss_cnt_r  <= miss_cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bi_r    <= bi;
      gi_r    <= gi;
      ci_r    <= ci;
      taken_r <= in_tdata[ADDR_W];
    end
    if (look_go) begin
      out_pred_r  <= pred;
      out_miss_r  <= miss;
      out_useg_r  <= use_g;
      out_total_r <= miss_cnt_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - ADDR_W - 3){1'b0}}, out_total_r,
                       out_useg_r, out_miss_r, out_pred_r};

`ifndef SYNTHESIS
  a_accept_to_look: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_LOOK)
    else $error("accepted branch did not enter resolve state");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !in_tready)
    else $error("input ready during table clearing");

  a_result_from_look: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_LOOK))
    else $error("result appeared without a resolve cycle");

  a_miss_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> miss_cnt_r >= $past(miss_cnt_r))
    else $error("miss total decreased");
`endif

endmodule
`default_nettype wire
